FILE: design/ssc_pkg.sv
// Shared types, constants and helpers for the substring search and count block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package ssc_pkg;

	// Widths fixed by the register map and the result fields
	localparam int PatMaxDef = 16;  // default window depth
	localparam int LenMax    = 16;  // longest pattern the registers can hold
	localparam int LenW      = 5;   // pattern_length register width
	localparam int HoldW     = 4;   // holdoff counter, at most LenMax - 1
	localparam int PosW      = 32;
	localparam int CntW      = 32;
	localparam int CfgW      = 64;
	localparam int IdxW      = 2;

	// Configuration register indexes
	typedef enum logic [IdxW-1:0] {
		CFG_PAT_LO  = 2'd0,
		CFG_PAT_HI  = 2'd1,
		CFG_PAT_LEN = 2'd2,
		CFG_START   = 2'd3
	} ssc_cfg_e;

	// Stage-one item travelling to the tally stage
	typedef struct packed {
		logic            valid;
		logic            last;
		logic [PosW-1:0] pos;
	} ssc_item_t;

	// Compare result for the item in stage one
	typedef struct packed {
		logic             hit;
		logic [HoldW-1:0] len_m1;
	} ssc_hit_t;

	// Pattern byte k of the 16-byte pattern; bytes 16 and up read as zero
	function automatic logic [7:0] pat_byte(input logic [2*CfgW-1:0] pat,
			input logic [LenW-1:0] k);
		logic [7:0] b;
		b = 8'd0;
		if (k < LenW'(LenMax)) begin
			b = pat[k[HoldW-1:0]*8 +: 8];
		end
		return b;
	endfunction

endpackage

FILE: design/ssc_window.sv
// Stage one: sliding byte window, fill count and text position.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
module ssc_window #(
	parameter int PATTERN_MAX = ssc_pkg::PatMaxDef
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              advance,
	input  logic [7:0]                        text_byte,
	input  logic                              last_byte,
	output logic [PATTERN_MAX-1:0][7:0]       win,
	output logic [$clog2(PATTERN_MAX+1)-1:0]  fill,
	output ssc_pkg::ssc_item_t                item
);
	import ssc_pkg::*;

	localparam int FillW = $clog2(PATTERN_MAX + 1);

	logic [PATTERN_MAX-1:0][7:0] win_q;
	logic [FillW-1:0]            fill_q;
	logic [PosW-1:0]             pos_q;    // position of the next byte
	logic                        last_q;   // last accepted byte closed a text
	logic                        valid_s1;
	logic [PosW-1:0]             cur_s1;

	logic [FillW-1:0] fill_base;
	logic [PosW-1:0]  pos_base;

	// A closed text starts the next one from empty state
	assign fill_base = last_q ? '0 : fill_q;
	assign pos_base  = last_q ? '0 : pos_q;

	// Window shift, counters and the stage-one request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			fill_q   <= '0;
			pos_q    <= '0;
			last_q   <= 1'b0;
			valid_s1 <= 1'b0;
			cur_s1   <= '0;
		end else begin
			if (accept) begin
				for (int k = PATTERN_MAX - 1; k > 0; k--) begin
					win_q[k] <= last_q ? 8'd0 : win_q[k-1];
				end
				win_q[0] <= text_byte;
				fill_q   <= (fill_base < FillW'(PATTERN_MAX)) ? fill_base + 1'b1 : fill_base;
				pos_q    <= (&pos_base) ? pos_base : pos_base + 1'b1;
				cur_s1   <= pos_base;
				last_q   <= last_byte;
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign win        = win_q;
	assign fill       = fill_q;
	assign item.valid = valid_s1;
	assign item.last  = last_q;
	assign item.pos   = cur_s1;

endmodule

FILE: design/ssc_match.sv
// Parallel compare of the window against the configured pattern.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
module ssc_match #(
	parameter int PATTERN_MAX = ssc_pkg::PatMaxDef
) (
	input  logic [PATTERN_MAX-1:0][7:0]       win,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]  fill,
	input  logic [2*ssc_pkg::CfgW-1:0]        pat,
	input  logic [ssc_pkg::LenW-1:0]          pat_len,
	output ssc_pkg::ssc_hit_t                 hit
);
	import ssc_pkg::*;

	localparam int LenCap = (PATTERN_MAX < LenMax) ? PATTERN_MAX : LenMax;

	logic [LenW-1:0] len;
	logic            ok;

	// Effective length: zero means one, clamp to the window depth
	always_comb begin
		len = pat_len;
		if (len == '0) begin
			len = LenW'(1);
		end
		if (len > LenW'(LenCap)) begin
			len = LenW'(LenCap);
		end
	end

	// Window entry k holds the byte that must equal pattern byte len-1-k
	always_comb begin
		ok = (int'(fill) >= int'(len));
		for (int k = 0; k < PATTERN_MAX; k++) begin
			if (k < int'(len)) begin
				if (win[k] != pat_byte(pat, len - 1'b1 - LenW'(k))) begin
					ok = 1'b0;
				end
			end
		end
	end

	assign hit.hit    = ok;
	assign hit.len_m1 = HoldW'(len - 1'b1);

endmodule

FILE: design/ssc_tally.sv
// Stage two: first-match tracking, non-overlapping count and result register.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
module ssc_tally (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ssc_pkg::ssc_item_t         item,
	input  logic                       advance,
	input  ssc_pkg::ssc_hit_t          hit,
	input  logic [ssc_pkg::PosW-1:0]   search_start,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic                       found,
	output logic [ssc_pkg::PosW-1:0]   first_position,
	output logic [ssc_pkg::CntW-1:0]   match_count
);
	import ssc_pkg::*;

	logic             first_valid_q;
	logic [PosW-1:0]  first_pos_q;
	logic [HoldW-1:0] holdoff_q;
	logic [CntW-1:0]  count_q;
	logic             out_valid_q;
	logic             found_q;
	logic [PosW-1:0]  first_out_q;
	logic [CntW-1:0]  count_out_q;

	logic [PosW-1:0]  start;
	logic             fv_n;
	logic [PosW-1:0]  fp_n;
	logic [HoldW-1:0] ho_n;
	logic [CntW-1:0]  cnt_n;

	assign start = item.pos - PosW'(hit.len_m1);

	// Next tally for the item leaving stage one
	always_comb begin
		fv_n  = first_valid_q;
		fp_n  = first_pos_q;
		ho_n  = holdoff_q;
		cnt_n = count_q;
		if (hit.hit && !first_valid_q && (start >= search_start)) begin
			fv_n = 1'b1;
			fp_n = start;
		end
		if (holdoff_q != '0) begin
			ho_n = holdoff_q - 1'b1;
		end else if (hit.hit) begin
			cnt_n = (&count_q) ? count_q : count_q + 1'b1;
			ho_n  = hit.len_m1;
		end
	end

	// Running state; cleared when a text closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_valid_q <= 1'b0;
			first_pos_q   <= '0;
			holdoff_q     <= '0;
			count_q       <= '0;
		end else if (advance) begin
			if (item.last) begin
				first_valid_q <= 1'b0;
				first_pos_q   <= '0;
				holdoff_q     <= '0;
				count_q       <= '0;
			end else begin
				first_valid_q <= fv_n;
				first_pos_q   <= fp_n;
				holdoff_q     <= ho_n;
				count_q       <= cnt_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item.last) begin
			found_q     <= fv_n;
			first_out_q <= fv_n ? fp_n : '0;
			count_out_q <= cnt_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign first_position = first_out_q;
	assign match_count    = count_out_q;

endmodule

FILE: design/substring_search_and_count.sv
// Streaming substring search and non-overlapping match count, top level.
// The result is registered: the last byte's request passes the stage-one register, then the result register.
// Throughput: one text byte per cycle while not stalled, set by the combinational window compare.
// A waiting result stalls the input only while another closing item waits in stage one.
// Reset is asynchronous: control and configuration registers return to defaults, all text state clears.
// Depends on ssc_pkg, ssc_window, ssc_match, ssc_tally.
`timescale 1ns / 1ps
module substring_search_and_count #(
	parameter int PATTERN_MAX = ssc_pkg::PatMaxDef
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_wen,
	input  logic [ssc_pkg::IdxW-1:0]   cfg_index,
	input  logic [ssc_pkg::CfgW-1:0]   cfg_wdata,
	// text stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] text_byte
	input  logic                       s_tlast,   // last_byte
	// result stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [63:0]                m_tdata,   // [31:0] first_position, [63:32] match_count
	output logic                       m_tuser    // [0] found
);
	import ssc_pkg::*;

	localparam int FillW = $clog2(PATTERN_MAX + 1);

	logic [CfgW-1:0] pat_lo_q;
	logic [CfgW-1:0] pat_hi_q;
	logic [LenW-1:0] pat_len_q;
	logic [PosW-1:0] start_q;

	logic [PATTERN_MAX-1:0][7:0] win;
	logic [FillW-1:0]            fill;
	ssc_item_t                   item;
	ssc_hit_t                    hit;
	logic                        accept;
	logic                        advance;
	logic                        stall;
	logic                        found;
	logic [PosW-1:0]             first_position;
	logic [CntW-1:0]             match_count;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= LenW'(1);
			start_q   <= '0;
		end else if (cfg_wen) begin
			unique case (ssc_cfg_e'(cfg_index))
				CFG_PAT_LO:  pat_lo_q  <= cfg_wdata;
				CFG_PAT_HI:  pat_hi_q  <= cfg_wdata;
				CFG_PAT_LEN: pat_len_q <= cfg_wdata[LenW-1:0];
				CFG_START:   start_q   <= cfg_wdata[PosW-1:0];
				default: ;
			endcase
		end
	end

	// Stage one holds while a closing item waits on a full result register
	assign stall    = item.valid && item.last && m_tvalid && !m_tready;
	assign advance  = item.valid && !stall;
	assign s_tready = !stall;
	assign accept   = s_tvalid && s_tready;

	ssc_window #(.PATTERN_MAX(PATTERN_MAX)) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.advance   (advance),
		.text_byte (s_tdata),
		.last_byte (s_tlast),
		.win       (win),
		.fill      (fill),
		.item      (item)
	);

	ssc_match #(.PATTERN_MAX(PATTERN_MAX)) u_match (
		.win     (win),
		.fill    (fill),
		.pat     ({pat_hi_q, pat_lo_q}),
		.pat_len (pat_len_q),
		.hit     (hit)
	);

	ssc_tally u_tally (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.advance        (advance),
		.hit            (hit),
		.search_start   (start_q),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.found          (found),
		.first_position (first_position),
		.match_count    (match_count)
	);

	assign m_tdata = {match_count, first_position};
	assign m_tuser = found;

	// A result with no match reports position zero
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:0] == 32'd0)
		else $error("first_position nonzero without a match");

	// Any match found implies at least one counted match
	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[63:32] != 32'd0)
		else $error("match found but count is zero");

	// Input only stalls behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready && item.valid && item.last)
		else $error("input stalled without a blocked result");

	// A new result follows a closing item leaving stage one
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(advance && item.last))
		else $error("result appeared without a closing item");

endmodule

FILE: tb/tb_substring_search_and_count.sv
// Self-checking testbench for substring_search_and_count: text byte requests with random
// content, patterns and idling, checked against an in-bench search predictor.
// Depends on ssc_pkg and the substring_search_and_count RTL.
`timescale 1ns / 1ps
module tb_substring_search_and_count;
	import ssc_pkg::*;

	localparam int PatDepth   = 16;
	localparam int CycleLimit = 200000;
	localparam int ShowMax    = 10;

	typedef struct packed {
		logic            last;
		logic [7:0]      data;
	} text_req_t;

	typedef struct packed {
		logic            found;
		logic [PosW-1:0] first_position;
		logic [CntW-1:0] match_count;
	} search_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [IdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic m_tuser;

	// stimulus and expectations
	text_req_t text_q[$];
	search_result_t pending_results[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int cycles = 0;

	// shadow of the configuration registers
	logic [CfgW-1:0] pat_lo = '0;
	logic [CfgW-1:0] pat_hi = '0;
	logic [LenW-1:0] pat_len = LenW'(1);
	logic [PosW-1:0] search_from = '0;

	// predictor text state
	logic [7:0] win [PatDepth];
	int win_fill;
	logic [PosW-1:0] text_pos;
	int holdoff;
	logic [CntW-1:0] tally;
	logic first_valid;
	logic [PosW-1:0] first_pos;

	search_result_t got, want;

	substring_search_and_count dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),      // [7:0] text_byte
		.s_tlast(s_tlast),      // last_byte
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),      // [31:0] first_position, [63:32] match_count
		.m_tuser(m_tuser)       // [0] found
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// effective pattern length: zero reads as one, clamp to the window depth
	function automatic int active_len();
		int len;
		len = int'(pat_len);
		if (len == 0) len = 1;
		if (len > PatDepth) len = PatDepth;
		return len;
	endfunction

	function automatic logic [7:0] pat_at(input int k);
		logic [2*CfgW-1:0] pat;
		pat = {pat_hi, pat_lo};
		if (k >= 16) return 8'd0;
		return pat[k*8 +: 8];
	endfunction

	function automatic void start_new_text();
		for (int i = 0; i < PatDepth; i++) win[i] = 8'd0;
		win_fill = 0;
		text_pos = '0;
		holdoff = 0;
		tally = '0;
		first_valid = 1'b0;
		first_pos = '0;
	endfunction

	// one accepted text byte: slide the window, test for a match ending here
	function automatic void advance_search(input logic [7:0] b, input logic last);
		int len;
		logic hit;
		logic [PosW-1:0] start;
		search_result_t r;
		len = active_len();
		for (int i = PatDepth - 1; i > 0; i--) win[i] = win[i-1];
		win[0] = b;
		if (win_fill < PatDepth) win_fill++;
		hit = (win_fill >= len);
		for (int j = 0; j < len; j++) begin
			if (win[len-1-j] != pat_at(j)) hit = 1'b0;
		end
		if (hit) begin
			start = text_pos - PosW'(len - 1);
			if (!first_valid && start >= search_from) begin
				first_valid = 1'b1;
				first_pos = start;
			end
		end
		// greedy non-overlapping count
		if (holdoff > 0) begin
			holdoff--;
		end else if (hit) begin
			if (tally != '1) tally++;
			holdoff = len - 1;
		end
		if (text_pos != '1) text_pos++;
		if (last) begin
			r.found = first_valid;
			r.first_position = first_valid ? first_pos : '0;
			r.match_count = tally;
			pending_results.push_back(r);
			start_new_text();
		end
	endfunction

	// text driver: holds a request until accepted, idles at random
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				advance_search(text_q[0].data, text_q[0].last);
				void'(text_q.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (text_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= text_q[0].data;
					s_tlast <= text_q[0].last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor: random backpressure, compare against oldest expectation
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_tvalid && m_tready) begin
				got.found = m_tuser;
				got.first_position = m_tdata[31:0];
				got.match_count = m_tdata[63:32];
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= ShowMax)
						$display("unexpected result: found=%0b pos=%0d count=%0d",
							got.found, got.first_position, got.match_count);
				end else begin
					want = pending_results.pop_front();
					if (got.found !== want.found || got.first_position !== want.first_position ||
							got.match_count !== want.match_count) begin
						mismatches++;
						if (mismatches <= ShowMax)
							$display("mismatch: exp found=%0b pos=%0d count=%0d, got found=%0b pos=%0d count=%0d",
								want.found, want.first_position, want.match_count,
								got.found, got.first_position, got.match_count);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(input ssc_cfg_e idx, input logic [CfgW-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_PAT_LO:  pat_lo = val;
			CFG_PAT_HI:  pat_hi = val;
			CFG_PAT_LEN: pat_len = val[LenW-1:0];
			CFG_START:   search_from = val[PosW-1:0];
			default: ;
		endcase
	endtask

	// write every register; only called with the block idle
	task automatic configure(input logic [CfgW-1:0] lo, input logic [CfgW-1:0] hi,
			input logic [CfgW-1:0] len, input logic [CfgW-1:0] start);
		write_reg(CFG_PAT_LO, lo);
		write_reg(CFG_PAT_HI, hi);
		write_reg(CFG_PAT_LEN, len);
		write_reg(CFG_START, start);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		text_req_t t;
		t.data = b;
		t.last = last;
		text_q.push_back(t);
	endtask

	// one text of exactly n bytes, mostly pattern bytes with embedded copies
	task automatic queue_text(input int n);
		int len;
		int k;
		logic [7:0] b;
		len = active_len();
		k = 0;
		while (k < n) begin
			if ($urandom_range(3) == 0 && k + len <= n) begin
				for (int j = 0; j < len; j++) push_byte(pat_at(j), (k + j == n - 1));
				k += len;
			end else begin
				case ($urandom_range(9))
					0: b = 8'($urandom_range(255));
					1: b = pat_at(0);
					default: b = pat_at($urandom_range(len - 1));
				endcase
				push_byte(b, (k == n - 1));
				k++;
			end
		end
	endtask

	// drain: no request left, nothing expected, then let the pipeline settle
	task automatic wait_idle();
		while (text_q.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int len;
		int queued;
		int n;
		logic [CfgW-1:0] lo, hi, len_val, start_val;
		start_new_text();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// overlapping candidates and a text shorter than the pattern
		configure(64'hAAAA, 64'd0, 64'd2, 64'd0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'hAA, 1'b1);
		push_byte(8'hAA, 1'b1);
		wait_idle();
		// zero length acts as one, search starts past position zero
		configure(64'hFF, 64'd0, 64'd0, 64'd1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		wait_idle();
		// length above sixteen clamps; start at the top of the range
		configure('1, 64'd0, 64'd31, 64'hFFFF_FFFF);
		for (int i = 0; i < 16; i++) push_byte((i < 8) ? 8'hFF : 8'h00, (i == 15));
		wait_idle();

		// random phases cycling through the idling modes
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
			// small alphabet makes matches frequent
			if ($urandom_range(1) == 0) begin
				lo &= 64'h0101_0101_0101_0101;
				hi &= 64'h0101_0101_0101_0101;
			end
			case ($urandom_range(9))
				0: len_val = 64'd0;
				1: len_val = 64'($urandom_range(31, 17));
				2: len_val = 64'd16;
				3: len_val = 64'd1;
				default: len_val = 64'($urandom_range(6, 2));
			endcase
			case ($urandom_range(5))
				0: start_val = 64'd0;
				1: start_val = 64'hFFFF_FFFF;
				2: start_val = 64'($urandom);
				default: start_val = 64'($urandom_range(20));
			endcase
			configure(lo, hi, len_val, start_val);
			len = active_len();
			queued = 0;
			while (queued < 78) begin
				if ($urandom_range(7) == 0)
					n = $urandom_range((len > 1) ? len - 1 : 1, 1);
				else
					n = $urandom_range(3 * len + 10, 1);
				queue_text(n);
				queued += n;
			end
			wait_idle();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
